// ===== rtl/gss_pkg.sv =====
// ----------------------------------------------------------------------------
// gss_pkg
// Types and constants shared by the grid subdivision step blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package gss_pkg;

  localparam int COORD_W     = 20;
  localparam int POS_W       = 7;
  localparam int CFG_W       = 7;
  localparam int VERT_W      = COORD_W + 4;   // column sums, weights up to 8
  localparam int HORZ_W      = COORD_W + 8;   // full sum in 64ths
  localparam int ROUND_SHIFT = 6;
  localparam int ROUND_HALF  = 32;

  typedef enum logic [0:0] {
    REG_GRID_ROWS = 1'b0,
    REG_GRID_COLS = 1'b1
  } cfg_reg_t;

  // output row picked within a run
  typedef enum logic [1:0] {
    ROW_EVEN = 2'd0,   // row 2r-2
    ROW_ODD  = 2'd1,   // row 2r-1
    ROW_LAST = 2'd2    // row 2r, last input row only
  } row_sel_t;

  // output column picked within a run
  typedef enum logic [1:0] {
    COL_ODD_LEFT  = 2'd0,  // col 2c-3
    COL_EVEN      = 2'd1,  // col 2c-2
    COL_ODD_RIGHT = 2'd2,  // col 2c-1, last input column only
    COL_LAST      = 2'd3   // col 2c, last input column only
  } col_sel_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic [POS_W-1:0]          out_row;
    logic [POS_W-1:0]          out_col;
    logic                      run_last;
    logic                      grid_done;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vtx_t;

  // one line store entry: the column's vertex in the previous two rows
  typedef struct packed {
    vtx_t newer;
    vtx_t older;
  } pair_t;

  // 3x3 neighborhood, [row][col], row 2 / col 2 is the newest vertex
  typedef vtx_t [2:0][2:0] win_t;

  typedef struct packed {
    logic             emit;      // row >= 1 and col >= 1
    logic             rb0;       // row 1: upper output row sits on the top edge
    logic             cb0;       // col 1: left output col sits on the left edge
    logic             col_ge2;
    logic             last_row;
    logic             last_col;
    logic [POS_W-1:0] row_base;  // 2r-2
    logic [POS_W-1:0] col_base;  // 2c-3
  } pos_info_t;

  typedef struct packed {
    row_sel_t ar;
    logic     rb0;
    col_sel_t bc;
    logic     cb0;
  } lane_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/grid_subdivision_step_core.sv =====
// ----------------------------------------------------------------------------
// grid_subdivision_step_core
// One Catmull-Clark subdivision pass over a regular grid of 3-D points.
// ----------------------------------------------------------------------------
// Vertices stream in row-major; each one produces 0 to 12 subdivided points,
// one per clock on the output while out_stall is low (about four per vertex
// on average). A vertex is taken while the previous one's points are still
// going out; the input stalls only once a vertex waits in the input stage and
// the window still has points to send, so the sustained rate is set by the
// output at one point per cycle unless out_stall holds it. The line store holds
// two rows of MAX_COLS entries in one memory, read once and written once per
// vertex. Points pass the lane sum registers and then the output register.
// Writing grid_rows or grid_cols restarts the grid at row 0, column 0.
`default_nettype none

module grid_subdivision_step_core import gss_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int RW  = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
  localparam int CNW = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;

  logic [CFG_W-1:0] grid_rows_r, grid_cols_r;
  logic [RW-1:0]    row_last;
  logic [CNW-1:0]   col_last;

  logic      a_valid, load, win_free, issue, is_last, en;
  pos_info_t a_info, win_info;
  win_t      win;

  logic      win_busy_r;
  row_sel_t  ar_r, last_ar;
  col_sel_t  bc_r, last_bc, first_bc;

  lane_ctl_t ctl;
  logic [2:0][2:0][COORD_W-1:0] cx, cy, cz;
  logic signed [COORD_W-1:0] rx, ry, rz;

  logic             p1_v_r, p2_v_r, out_valid_r;
  logic [POS_W-1:0] p1_row_r, p1_col_r, p2_row_r, p2_col_r;
  logic             p1_last_r, p1_done_r, p2_last_r, p2_done_r;
  out_item_t        out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= CFG_W'(2);
      grid_cols_r <= CFG_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_ROWS: grid_rows_r <= cfg_data;
        REG_GRID_COLS: grid_cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sizes clamp to 2..MAX
  always_comb begin
    priority if (grid_rows_r < CFG_W'(2))   row_last = RW'(1);
    else if (32'(grid_rows_r) > MAX_ROWS)   row_last = RW'(MAX_ROWS - 1);
    else                                    row_last = RW'(grid_rows_r - 1'b1);
    priority if (grid_cols_r < CFG_W'(2))   col_last = CNW'(1);
    else if (32'(grid_cols_r) > MAX_COLS)   col_last = CNW'(MAX_COLS - 1);
    else                                    col_last = CNW'(grid_cols_r - 1'b1);
  end

  gss_window #(
    .MAX_COLS (MAX_COLS),
    .RW       (RW),
    .CNW      (CNW)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_clear (cfg_we),
    .row_last  (row_last),
    .col_last  (col_last),
    .load      (load),
    .a_valid   (a_valid),
    .a_info    (a_info),
    .win_info  (win_info),
    .win       (win)
  );

  // ---- point sequencer ----
  assign en       = !out_valid_r || !out_stall;
  assign last_ar  = win_info.last_row ? ROW_LAST : ROW_ODD;
  assign last_bc  = win_info.last_col ? COL_LAST : COL_EVEN;
  assign first_bc = win_info.col_ge2 ? COL_ODD_LEFT : COL_EVEN;
  assign is_last  = (ar_r == last_ar) && (bc_r == last_bc);
  assign issue    = win_busy_r && en;
  assign win_free = !win_busy_r || (issue && is_last);
  assign load     = a_valid && win_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_busy_r <= 1'b0;
      ar_r       <= ROW_EVEN;
      bc_r       <= COL_EVEN;
    end else if (load) begin
      win_busy_r <= a_info.emit;
      ar_r       <= ROW_EVEN;
      bc_r       <= a_info.col_ge2 ? COL_ODD_LEFT : COL_EVEN;
    end else if (issue) begin
      if (is_last) begin
        win_busy_r <= 1'b0;
      end else if (bc_r == last_bc) begin
        bc_r <= first_bc;
        ar_r <= row_sel_t'(ar_r + 2'd1);
      end else begin
        bc_r <= col_sel_t'(bc_r + 2'd1);
      end
    end
  end

  // ---- lanes, one per axis ----
  assign ctl = '{ar: ar_r, rb0: win_info.rb0, bc: bc_r, cb0: win_info.cb0};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int m = 0; m < 3; m++) begin
        cx[k][m] = win[k][m].x;
        cy[k][m] = win[k][m].y;
        cz[k][m] = win[k][m].z;
      end
    end
  end

  gss_lane u_lane_x (.clk(clk), .en(en), .ctl(ctl), .cells(cx), .res(rx));
  gss_lane u_lane_y (.clk(clk), .en(en), .ctl(ctl), .cells(cy), .res(ry));
  gss_lane u_lane_z (.clk(clk), .en(en), .ctl(ctl), .cells(cz), .res(rz));

  // ---- tags alongside the lanes, then merge into the output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      p1_v_r      <= issue;
      p2_v_r      <= p1_v_r;
      out_valid_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_row_r  <= win_info.row_base + POS_W'(ar_r);
      p1_col_r  <= win_info.col_base + POS_W'(bc_r);
      p1_last_r <= is_last;
      p1_done_r <= (ar_r == ROW_LAST) && (bc_r == COL_LAST);
      p2_row_r  <= p1_row_r;
      p2_col_r  <= p1_col_r;
      p2_last_r <= p1_last_r;
      p2_done_r <= p1_done_r;
      out_data_r <= '{out_x: rx, out_y: ry, out_z: rz, out_row: p2_row_r,
                      out_col: p2_col_r, run_last: p2_last_r, grid_done: p2_done_r};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/gss_window.sv =====
// ----------------------------------------------------------------------------
// gss_window
// Grid position counters, two-row line store and the 3x3 vertex window.
// ----------------------------------------------------------------------------
`default_nettype none

module gss_window import gss_pkg::*; #(
  parameter int MAX_COLS = 64,
  parameter int RW       = 6,
  parameter int CNW      = 6
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire in_item_t       in_data,
  input  wire logic           cfg_clear,
  input  wire logic [RW-1:0]  row_last,
  input  wire logic [CNW-1:0] col_last,
  input  wire logic           load,
  output logic                a_valid,
  output pos_info_t           a_info,
  output pos_info_t           win_info,
  output win_t                win
);

  logic            a_valid_r;
  in_item_t        a_data_r;
  pos_info_t       a_info_r;
  logic [CNW-1:0]  a_col_r;
  logic [RW-1:0]   row_cnt_r;
  logic [CNW-1:0]  col_cnt_r;
  pos_info_t       info_nxt;
  pair_t           mem [MAX_COLS];
  pair_t           rd_r;
  win_t            win_r;
  pos_info_t       win_info_r;
  vtx_t            a_vtx;
  logic            accept;

  assign in_stall = a_valid_r && !load;
  assign accept   = in_valid && !in_stall;
  assign a_valid  = a_valid_r;
  assign a_info   = a_info_r;
  assign win_info = win_info_r;
  assign win      = win_r;

  assign a_vtx = '{x: a_data_r.coord_x, y: a_data_r.coord_y, z: a_data_r.coord_z};

  always_comb begin
    info_nxt.emit     = (row_cnt_r != '0) && (col_cnt_r != '0);
    info_nxt.rb0      = (row_cnt_r == RW'(1));
    info_nxt.cb0      = (col_cnt_r == CNW'(1));
    info_nxt.col_ge2  = (col_cnt_r > CNW'(1));
    info_nxt.last_row = (row_cnt_r == row_last);
    info_nxt.last_col = (col_cnt_r == col_last);
    info_nxt.row_base = POS_W'({row_cnt_r, 1'b0}) - POS_W'(2);
    info_nxt.col_base = POS_W'({col_cnt_r, 1'b0}) - POS_W'(3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      row_cnt_r <= '0;
      col_cnt_r <= '0;
    end else begin
      if (cfg_clear) begin
        row_cnt_r <= '0;
        col_cnt_r <= '0;
      end else if (accept) begin
        if (col_cnt_r == col_last) begin
          col_cnt_r <= '0;
          row_cnt_r <= (row_cnt_r == row_last) ? '0 : RW'(row_cnt_r + 1'b1);
        end else begin
          col_cnt_r <= CNW'(col_cnt_r + 1'b1);
        end
      end
      if (accept) begin
        a_valid_r <= 1'b1;
      end else if (load) begin
        a_valid_r <= 1'b0;
      end
    end
  end

  // read at accept, write back the shifted pair when the item enters the window
  always_ff @(posedge clk) begin
    if (accept) begin
      a_data_r <= in_data;
      a_info_r <= info_nxt;
      a_col_r  <= col_cnt_r;
      rd_r     <= mem[col_cnt_r];
    end
    if (load) begin
      mem[a_col_r] <= '{newer: a_vtx, older: rd_r.newer};
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= win_r[k][1];
        win_r[k][1] <= win_r[k][2];
      end
      win_r[0][2] <= rd_r.older;
      win_r[1][2] <= rd_r.newer;
      win_r[2][2] <= a_vtx;
      win_info_r  <= a_info_r;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gss_lane.sv =====
// ----------------------------------------------------------------------------
// gss_lane
// One coordinate axis: separable weighted sum over the 3x3 window, rounding
// and saturation. Two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module gss_lane import gss_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire lane_ctl_t                     ctl,
  input  wire logic [2:0][2:0][COORD_W-1:0]  cells,
  output logic signed [COORD_W-1:0]          res
);

  localparam logic signed [HORZ_W-1:0] SAT_MAX = HORZ_W'((64'sd1 <<< (COORD_W - 1)) - 1);
  localparam logic signed [HORZ_W-1:0] SAT_MIN = -HORZ_W'(64'sd1 <<< (COORD_W - 1));

  logic signed [VERT_W-1:0] v_nxt [3];
  logic signed [VERT_W-1:0] v_r   [3];
  col_sel_t                 bc_r;
  logic                     cb0_r;
  logic signed [HORZ_W-1:0] h_nxt;
  logic signed [HORZ_W-1:0] h_r;
  logic signed [HORZ_W-1:0] hv0, hv1, hv2;
  logic signed [HORZ_W-1:0] t;
  logic signed [HORZ_W-1:0] q;

  // vertical weights: (1,6,1) even row, (8) on the edge, (4,4) odd row
  always_comb begin
    logic signed [VERT_W-1:0] w0, w1, w2;
    for (int m = 0; m < 3; m++) begin
      w0 = VERT_W'($signed(cells[0][m]));
      w1 = VERT_W'($signed(cells[1][m]));
      w2 = VERT_W'($signed(cells[2][m]));
      unique case (ctl.ar)
        ROW_EVEN: v_nxt[m] = ctl.rb0 ? (w1 <<< 3) : (w0 + (w1 <<< 2) + (w1 <<< 1) + w2);
        ROW_ODD:  v_nxt[m] = (w1 + w2) <<< 2;
        ROW_LAST: v_nxt[m] = w2 <<< 3;
        default:  v_nxt[m] = '0;
      endcase
    end
  end

  assign hv0 = HORZ_W'(v_r[0]);
  assign hv1 = HORZ_W'(v_r[1]);
  assign hv2 = HORZ_W'(v_r[2]);

  always_comb begin
    unique case (bc_r)
      COL_ODD_LEFT:  h_nxt = (hv0 + hv1) <<< 2;
      COL_EVEN:      h_nxt = cb0_r ? (hv1 <<< 3) : (hv0 + (hv1 <<< 2) + (hv1 <<< 1) + hv2);
      COL_ODD_RIGHT: h_nxt = (hv1 + hv2) <<< 2;
      COL_LAST:      h_nxt = hv2 <<< 3;
      default:       h_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r   <= v_nxt;
      bc_r  <= ctl.bc;
      cb0_r <= ctl.cb0;
      h_r   <= h_nxt;
    end
  end

  // round half up from 64ths, then clamp
  assign t = h_r + HORZ_W'(ROUND_HALF);
  assign q = t >>> ROUND_SHIFT;

  always_comb begin
    priority if (q > SAT_MAX) res = COORD_W'(SAT_MAX);
    else if (q < SAT_MIN)     res = COORD_W'(SAT_MIN);
    else                      res = COORD_W'(q);
  end

endmodule

`default_nettype wire

// ===== rtl/gss_checker.sv =====
// ----------------------------------------------------------------------------
// gss_checker
// Port-level checks for grid_subdivision_step_core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gss_checker import gss_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // a held request keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output request changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // the grid's final point closes its run and sits on even row and column
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.grid_done |->
      out_data.run_last && !out_data.out_row[0] && !out_data.out_col[0])
    else $error("grid_done on a point that cannot end the grid");

  // every run ends on an even output column
  a_run_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.run_last |-> !out_data.out_col[0])
    else $error("run ends on an odd column");

endmodule

bind grid_subdivision_step_core gss_checker u_gss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
